/* hdl/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the error sigma-clip filter
// Controller states, command and status bundles, result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

   // clip threshold register, unsigned Q8.8
   localparam int SIGMA_BITS = 16;
   localparam logic [SIGMA_BITS-1:0] SIGMA_RESET = 16'd768;
   // lhs of the clip test is scaled by 2^16 (Q8.8 squared)
   localparam int FRAC_SHIFT = 16;

   // word kinds
   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FEW      = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_code_type;

   // serial multiplier operations
   typedef enum logic [1:0] {
      MUL_SUMSQ = 2'd0,  // n * sum(x^2)
      MUL_SUM   = 2'd1,  // sum(x) * sum(x)
      MUL_DEN   = 2'd2   // n * (n-1)
   } mul_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_CLS_SQ,
      S_CLS_LO,
      S_CLS_HI,
      S_CLS_CMP,
      S_SEL_INIT,
      S_SCAN,
      S_DECIDE,
      S_MEDIAN,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_DIV,
      S_FLOOR,
      S_SPREAD,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       load;
      logic       cls_first;
      logic       cls_sq;
      logic       cls_lo;
      logic       cls_hi;
      logic       cls_cmp;
      logic       sel_init;
      logic       sel_hi;
      logic       scan_start;
      logic       scan;
      logic       sel_decide;
      logic       sel_save_lo;
      logic       median_set;
      logic       mul_start;
      mul_op_type mul_op;
      logic       mul_step;
      logic       num_load;
      logic       num_sub;
      logic       den_load;
      logic       div_start;
      logic       div_step;
      logic       floor_sq;
      logic       spread;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic kind_cls;
      logic first_now;
      logic last;
      logic scan_done;
      logic sel_last;
      logic iter_done;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/esc_if.sv */
// ----------------------------------------------------------------------------
// esc_if: channel interfaces of the error sigma-clip filter
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface esc_req_if #(parameter int VALUE_BITS = 20);
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [VALUE_BITS-1:0] error_value;
   logic                  first_of_set;
   logic                  last_of_set;

   modport source (output valid, kind, error_value, first_of_set, last_of_set,
                   input ready);
   modport sink   (input valid, kind, error_value, first_of_set, last_of_set,
                   output ready);
endinterface

interface esc_rsp_if;
   logic       valid;
   logic       ready;
   logic       keep;
   logic [1:0] status;

   modport source (output valid, keep, status, input ready);
   modport sink   (input valid, keep, status, output ready);
endinterface

interface esc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [esc_pkg::SIGMA_BITS-1:0] sigma_limit;

   modport source (output valid, sigma_limit, input ready);
   modport sink   (input valid, sigma_limit, output ready);
endinterface

`default_nettype wire

/* hdl/esc_ctrl.sv */
// ----------------------------------------------------------------------------
// esc_ctrl: sequencing controller
// Handshakes, item decode, the classify steps and the statistics sequence (select, mul, divide).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   input  esc_pkg::stat_type stat,
   output esc_pkg::cmd_type  cmd
);

   esc_pkg::state_type state_ff, state_in;
   logic phase_ff, phase_in;    // 0: lower middle, 1: upper middle
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // state and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esc_pkg::S_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         esc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = esc_pkg::S_DECODE;
            end
         end
         esc_pkg::S_DECODE: begin
            if (stat.kind_cls) begin
               if (stat.first_now) begin
                  cmd.cls_first = 1'b1;
                  state_in      = esc_pkg::S_RESULT;
               end else begin
                  cmd.cls_sq = 1'b1;
                  state_in   = esc_pkg::S_CLS_LO;
               end
            end else begin
               cmd.load = 1'b1;
               if (stat.last) begin
                  phase_in = 1'b0;
                  state_in = esc_pkg::S_SEL_INIT;
               end else begin
                  state_in = esc_pkg::S_IDLE;
               end
            end
         end
         esc_pkg::S_CLS_SQ: begin
            cmd.cls_sq = 1'b1;
            state_in   = esc_pkg::S_CLS_LO;
         end
         esc_pkg::S_CLS_LO: begin
            cmd.cls_lo = 1'b1;
            state_in   = esc_pkg::S_CLS_HI;
         end
         esc_pkg::S_CLS_HI: begin
            cmd.cls_hi = 1'b1;
            state_in   = esc_pkg::S_CLS_CMP;
         end
         esc_pkg::S_CLS_CMP: begin
            cmd.cls_cmp = 1'b1;
            state_in    = esc_pkg::S_RESULT;
         end
         esc_pkg::S_SEL_INIT: begin
            cmd.sel_init   = 1'b1;
            cmd.sel_hi     = phase_ff;
            cmd.scan_start = 1'b1;
            state_in       = esc_pkg::S_SCAN;
         end
         esc_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = esc_pkg::S_DECIDE;
         end
         esc_pkg::S_DECIDE: begin
            cmd.sel_decide = 1'b1;
            if (stat.sel_last) begin
               if (!phase_ff) begin
                  cmd.sel_save_lo = 1'b1;
                  phase_in        = 1'b1;
                  state_in        = esc_pkg::S_SEL_INIT;
               end else begin
                  state_in = esc_pkg::S_MEDIAN;
               end
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = esc_pkg::S_SCAN;
            end
         end
         esc_pkg::S_MEDIAN: begin
            cmd.median_set = 1'b1;
            cmd.mul_start  = 1'b1;
            cmd.mul_op     = esc_pkg::MUL_SUMSQ;
            state_in       = esc_pkg::S_MUL1;
         end
         esc_pkg::S_MUL1: begin
            if (stat.iter_done) begin
               cmd.num_load  = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_op    = esc_pkg::MUL_SUM;
               state_in      = esc_pkg::S_MUL2;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         esc_pkg::S_MUL2: begin
            if (stat.iter_done) begin
               cmd.num_sub   = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_op    = esc_pkg::MUL_DEN;
               state_in      = esc_pkg::S_MUL3;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         esc_pkg::S_MUL3: begin
            if (stat.iter_done) begin
               cmd.den_load  = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = esc_pkg::S_DIV;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         esc_pkg::S_DIV: begin
            if (stat.iter_done) state_in = esc_pkg::S_FLOOR;
            else cmd.div_step = 1'b1;
         end
         esc_pkg::S_FLOOR: begin
            cmd.floor_sq = 1'b1;
            state_in     = esc_pkg::S_SPREAD;
         end
         esc_pkg::S_SPREAD: begin
            cmd.spread = 1'b1;
            state_in   = esc_pkg::S_RESULT;
         end
         esc_pkg::S_RESULT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = esc_pkg::S_IDLE;
            end
         end
         default: state_in = esc_pkg::S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/esc_dp.sv */
// ----------------------------------------------------------------------------
// esc_dp: datapath of the error sigma-clip filter
// Value store, running sums, radix median select, serial mul/div, clip test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_dp #(
   parameter int MAX_POINTS = 4096,
   parameter int VALUE_BITS = 20
) (
   input  wire                           clock,
   input  wire                           reset,
   input  esc_pkg::cmd_type              cmd,
   output esc_pkg::stat_type             stat,
   input  wire                           req_kind,
   input  wire  [VALUE_BITS-1:0]         req_value,
   input  wire                           req_first,
   input  wire                           req_last,
   input  wire                           csr_valid,
   input  wire  [esc_pkg::SIGMA_BITS-1:0] csr_sigma,
   output logic                          rsp_keep,
   output logic [1:0]                    rsp_status
);

   localparam int VB  = VALUE_BITS;
   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int XW  = 2 * VB;                // square of a value
   localparam int SW  = VB + CW;               // sum of values
   localparam int QW  = XW + CW;               // sum of squares
   localparam int NW  = XW + 2 * CW;           // variance numerator
   localparam int DW  = 2 * CW;                // variance denominator
   localparam int IW  = $clog2(NW + 1);        // serial step counter
   localparam int S2W = 2 * esc_pkg::SIGMA_BITS;
   localparam int PW  = S2W + VB;              // partial product
   localparam int RW  = S2W + XW;              // clip compare width

   // latched word
   logic          kind_ff, first_ff, last_ff;
   logic [VB-1:0] value_ff;

   // set state
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [SW-1:0] sum_ff;
   logic [QW-1:0] sumsq_ff;
   logic          first_pend_ff;
   logic [VB-1:0] median_ff;
   logic [XW-1:0] spread_ff;
   logic [esc_pkg::SIGMA_BITS-1:0] sigma_ff;

   // value store
   logic [VB-1:0] mem [MAX_POINTS];
   logic [VB-1:0] rd_data_ff;
   logic          rd_vld_ff;

   // median select
   logic [CW-1:0] addr_ff, cnt_ff, k_ff;
   logic [VB-1:0] sel_ff, mask_ff, bit_ff, lo_ff, sel_next;
   logic          match;

   // serial multiply / divide
   logic [NW-1:0] acc_ff, mcand_ff, num_ff;
   logic [SW-1:0] mplier_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   rem_ff, rem_try;
   logic [IW-1:0] iter_ff;
   logic [XW-1:0] floor_ff;

   // clip test
   logic [XW-1:0]  dsq_ff;
   logic [S2W-1:0] s2_ff;
   logic [PW-1:0]  plo_ff, phi_ff;
   logic [VB-1:0]  abs_diff;
   logic [RW-1:0]  lhs, rhs;

   logic          keep_ff;
   logic          rsp_keep_ff;
   logic [1:0]    rsp_status_ff;

   // load bookkeeping
   logic [CW-1:0] base;
   logic          full;
   assign base = first_ff ? '0 : count_ff;
   assign full = (base == CW'(MAX_POINTS));
   assign count_in = full ? base : base + 1'b1;
   assign ovf_in   = (first_ff ? 1'b0 : ovf_ff) | full;

   // latched word and set registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
         first_ff <= req_first;
         last_ff  <= req_last;
      end
      // sums start empty so a set begun without a start mark is clean
      if (reset) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (cmd.load && !full) begin
         sum_ff   <= (first_ff ? '0 : sum_ff) + SW'(value_ff);
         sumsq_ff <= (first_ff ? '0 : sumsq_ff) + QW'(XW'(value_ff) * XW'(value_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         first_pend_ff <= 1'b1;
         median_ff     <= '0;
         spread_ff     <= '0;
         sigma_ff      <= esc_pkg::SIGMA_RESET;
         rd_vld_ff     <= 1'b0;
      end else begin
         if (csr_valid) sigma_ff <= csr_sigma;
         if (cmd.load) begin
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
         if (cmd.cls_first) first_pend_ff <= 1'b0;
         if (cmd.spread) begin
            first_pend_ff <= 1'b1;
            spread_ff     <= (count_ff >= CW'(2) && num_ff[XW-1:0] > floor_ff)
                             ? num_ff[XW-1:0] : floor_ff;
         end
         if (cmd.median_set) begin
            median_ff <= (count_ff == '0) ? '0
                       : VB'(((VB+1)'(lo_ff) + (VB+1)'(sel_ff)) >> 1);
         end
         if (cmd.scan_start) rd_vld_ff <= 1'b0;
         else if (cmd.scan) rd_vld_ff <= (addr_ff != count_ff);
      end
   end

   // store write port
   always_ff @(posedge clock) begin
      if (cmd.load && !full) mem[base[AW-1:0]] <= value_ff;
   end

   // store read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr_ff[AW-1:0]];
   end

   // radix select: count values under the current prefix with a zero at the test bit
   assign match = (((rd_data_ff ^ sel_ff) & mask_ff) == '0) && ((rd_data_ff & bit_ff) == '0);
   assign sel_next = (k_ff < cnt_ff) ? sel_ff : (sel_ff | bit_ff);

   always_ff @(posedge clock) begin
      if (cmd.sel_init) begin
         sel_ff  <= '0;
         mask_ff <= '0;
         bit_ff  <= {1'b1, {(VB-1){1'b0}}};
         k_ff    <= cmd.sel_hi ? (count_ff >> 1) : ((count_ff - 1'b1) >> 1);
      end else if (cmd.sel_decide) begin
         if (!(k_ff < cnt_ff)) k_ff <= k_ff - cnt_ff;
         sel_ff  <= sel_next;
         mask_ff <= mask_ff | bit_ff;
         bit_ff  <= bit_ff >> 1;
      end
      if (cmd.sel_save_lo) lo_ff <= sel_next;
      if (cmd.scan_start) begin
         addr_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.scan) begin
         if (addr_ff != count_ff) addr_ff <= addr_ff + 1'b1;
         if (rd_vld_ff && match) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // shift-add multiplier and restoring divider
   assign rem_try = {rem_ff[DW-1:0], num_ff[NW-1]};

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         acc_ff  <= '0;
         iter_ff <= IW'(SW);
         case (cmd.mul_op)
            esc_pkg::MUL_SUMSQ: begin
               mcand_ff  <= NW'(sumsq_ff);
               mplier_ff <= SW'(count_ff);
            end
            esc_pkg::MUL_SUM: begin
               mcand_ff  <= NW'(sum_ff);
               mplier_ff <= sum_ff;
            end
            default: begin
               mcand_ff  <= NW'(count_ff);
               mplier_ff <= SW'(count_ff - 1'b1);
            end
         endcase
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         iter_ff   <= iter_ff - 1'b1;
      end else if (cmd.div_start) begin
         iter_ff <= IW'(NW);
      end else if (cmd.div_step) begin
         iter_ff <= iter_ff - 1'b1;
      end
      if (cmd.num_load) num_ff <= acc_ff;
      else if (cmd.num_sub) num_ff <= num_ff - acc_ff;
      else if (cmd.div_step) num_ff <= {num_ff[NW-2:0], (rem_try >= (DW+1)'(den_ff))};
      if (cmd.den_load) den_ff <= acc_ff[DW-1:0];
      if (cmd.div_start) rem_ff <= '0;
      else if (cmd.div_step)
         rem_ff <= (rem_try >= (DW+1)'(den_ff)) ? rem_try - (DW+1)'(den_ff) : rem_try;
      if (cmd.floor_sq) floor_ff <= (XW'(median_ff) * XW'(median_ff)) >> 2;
   end

   // clip test: (d^2 << 16) < sigma^2 * spread^2, spread split in two halves
   assign abs_diff = (value_ff > median_ff) ? value_ff - median_ff : median_ff - value_ff;
   assign lhs  = RW'({dsq_ff, {esc_pkg::FRAC_SHIFT{1'b0}}});
   assign rhs  = {phi_ff, {VB{1'b0}}} + RW'(plo_ff);

   always_ff @(posedge clock) begin
      if (cmd.cls_sq) begin
         dsq_ff <= XW'(abs_diff) * XW'(abs_diff);
         s2_ff  <= S2W'(sigma_ff) * S2W'(sigma_ff);
      end
      if (cmd.cls_lo) plo_ff <= PW'(s2_ff) * PW'(spread_ff[VB-1:0]);
      if (cmd.cls_hi) phi_ff <= PW'(s2_ff) * PW'(spread_ff[XW-1:VB]);
      if (cmd.cls_first) keep_ff <= 1'b1;
      else if (cmd.cls_cmp) keep_ff <= (lhs < rhs);
      else if (cmd.spread) keep_ff <= 1'b0;
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_keep_ff   <= keep_ff;
         rsp_status_ff <= ovf_ff ? esc_pkg::ST_OVERFLOW
                        : (count_ff < CW'(2) ? esc_pkg::ST_FEW : esc_pkg::ST_OK);
      end
   end

   assign rsp_keep   = rsp_keep_ff;
   assign rsp_status = rsp_status_ff;

   // status to the controller
   always_comb begin
      stat.kind_cls  = (kind_ff == esc_pkg::KIND_CLASSIFY);
      stat.first_now = first_ff || first_pend_ff;
      stat.last      = last_ff;
      stat.scan_done = (addr_ff == count_ff) && !rd_vld_ff;
      stat.sel_last  = bit_ff[0];
      stat.iter_done = (iter_ff == '0);
   end

endmodule

`default_nettype wire

/* hdl/error_sigma_clip_filter.sv */
// ----------------------------------------------------------------------------
// error_sigma_clip_filter: sigma clipping of measurement errors
// Load word: no result but on the last word. Classify word: the first of a pass
// goes straight to the result register, others through square, partial product
// and compare steps. Last load word: radix median select over the store read
// port, then three shift-add multiplies and a restoring divide for the variance.
// Sync reset empties the set, sigma_limit 3.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module error_sigma_clip_filter #(
   parameter int MAX_POINTS = 4096,
   parameter int VALUE_BITS = 20
) (
   input wire     clock,
   input wire     reset,
   esc_req_if.sink   req_ch,
   esc_rsp_if.source rsp_ch,
   esc_csr_if.sink   csr_ch
);

   esc_pkg::cmd_type  cmd;
   esc_pkg::stat_type stat;

   // register writes always accepted
   assign csr_ch.ready = 1'b1;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   esc_dp #(
      .MAX_POINTS (MAX_POINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_ch.kind),
      .req_value  (req_ch.error_value),
      .req_first  (req_ch.first_of_set),
      .req_last   (req_ch.last_of_set),
      .csr_valid  (csr_ch.valid),
      .csr_sigma  (csr_ch.sigma_limit),
      .rsp_keep   (rsp_ch.keep),
      .rsp_status (rsp_ch.status)
   );

endmodule

`default_nettype wire

/* hdl/esc_checker.sv */
// ----------------------------------------------------------------------------
// esc_checker: port-level checks of the error sigma-clip filter
// Result word hold, reset, status code range and silent load words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_kind,
   input wire       req_last,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_keep,
   input wire [1:0] rsp_status
);

   // stalled result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep) && $stable(rsp_status))
      else $error("result word changed under stall");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a load word that is not the last never makes a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == esc_pkg::KIND_LOAD && !req_last && !rsp_valid
      |=> !rsp_valid)
      else $error("result from an intermediate load word");

   // status carries a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == esc_pkg::ST_OK || rsp_status == esc_pkg::ST_FEW ||
                     rsp_status == esc_pkg::ST_OVERFLOW))
      else $error("undefined status code");

endmodule

bind error_sigma_clip_filter esc_checker u_esc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_kind   (req_ch.kind),
   .req_last   (req_ch.last_of_set),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_keep   (rsp_ch.keep),
   .rsp_status (rsp_ch.status)
);

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the error sigma-clip filter
// Runs directed and random load/classify passes through the request channel.
// A scoreboard model predicts each keep/status word. The threshold register
// is rewritten between idle phases, and responses are stalled at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int NPTS  = 4096;
   localparam int VBITS = 20;
   localparam logic [VBITS-1:0] VMAX = {VBITS{1'b1}};
   localparam logic [2*VBITS-1:0] SPREAD_MASK = {2*VBITS{1'b1}};
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic             kind;
      logic [VBITS-1:0] value;
      logic             first;
      logic             last;
   } word_type;

   typedef struct packed {
      logic                     keep;
      esc_pkg::status_code_type status;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   esc_req_if #(.VALUE_BITS(VBITS)) req_ch ();
   esc_rsp_if rsp_ch ();
   esc_csr_if csr_ch ();

   error_sigma_clip_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // pending request words and expected response words
   word_type    pending_words[$];
   verdict_type expected_verdicts[$];

   // filter model state
   logic [VBITS-1:0]   mdl_store[NPTS];
   int                 mdl_count;
   logic [VBITS-1:0]   mdl_median;
   logic [2*VBITS-1:0] mdl_spread_sq;
   bit                 mdl_overflow;
   bit                 mdl_first_pending;
   logic [15:0]        mdl_sigma;

   int err_count;
   int load_words, cls_words, rsp_words, set_count, sigma_writes;
   bit big_stall_done;

   // median, variance and spread floor of the stored set
   task automatic update_stats();
      logic [VBITS-1:0] sorted[$];
      logic [127:0] sum, sumsq, x, num, den;
      logic [63:0]  variance, floor_sq;
      int n;
      n = mdl_count;
      sorted = {};
      for (int i = 0; i < n; i++) sorted.push_back(mdl_store[i]);
      sorted.sort();
      if (n == 0)
         mdl_median = '0;
      else if (n % 2)
         mdl_median = sorted[n/2];
      else
         mdl_median = ({1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]}) >> 1;
      variance = '0;
      if (n >= 2) begin
         sum = '0;
         sumsq = '0;
         for (int i = 0; i < n; i++) begin
            x = mdl_store[i];
            sum += x;
            sumsq += x * x;
         end
         num = 128'(n) * sumsq - sum * sum;
         den = 128'(n) * 128'(n - 1);
         variance = 64'(num / den);
      end
      floor_sq = (64'(mdl_median) * 64'(mdl_median)) >> 2;
      mdl_spread_sq = (variance > floor_sq ? variance : floor_sq) & SPREAD_MASK;
   endtask

   // advance the model by one accepted word, queue any response
   task automatic predict_verdict(input word_type w);
      verdict_type v;
      logic [VBITS-1:0] abs_diff;
      logic [127:0] lhs, rhs;
      v.keep = 1'b0;
      if (w.kind == esc_pkg::KIND_LOAD) begin
         load_words++;
         if (w.first) begin
            mdl_count = 0;
            mdl_overflow = 1'b0;
         end
         if (mdl_count < NPTS) begin
            mdl_store[mdl_count] = w.value;
            mdl_count++;
         end else begin
            mdl_overflow = 1'b1;
         end
         if (!w.last) return;
         update_stats();
         mdl_first_pending = 1'b1;
         set_count++;
      end else begin
         cls_words++;
         if (w.first) mdl_first_pending = 1'b1;
         if (mdl_first_pending) begin
            v.keep = 1'b1;
            mdl_first_pending = 1'b0;
         end else begin
            abs_diff = (w.value > mdl_median) ? w.value - mdl_median
                                              : mdl_median - w.value;
            lhs = (128'(abs_diff) * 128'(abs_diff)) << esc_pkg::FRAC_SHIFT;
            rhs = 128'(mdl_sigma) * 128'(mdl_sigma) * 128'(mdl_spread_sq);
            v.keep = (lhs < rhs);
         end
      end
      v.status = mdl_overflow ? esc_pkg::ST_OVERFLOW
               : (mdl_count < 2 ? esc_pkg::ST_FEW : esc_pkg::ST_OK);
      expected_verdicts.push_back(v);
   endtask

   // idle lengths: mostly short, a few long, with bursts of none
   int req_burst, rsp_burst;
   function automatic int pick_gap(ref int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst = $urandom_range(10, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_verdict({req_ch.kind, req_ch.error_value,
                             req_ch.first_of_set, req_ch.last_of_set});
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               word_type w;
               w = pending_words.pop_front();
               req_ch.kind         <= w.kind;
               req_ch.error_value  <= w.value;
               req_ch.first_of_set <= w.first;
               req_ch.last_of_set  <= w.last;
               req_ch.valid        <= 1'b1;
               req_gap = pick_gap(req_burst);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response ready: random stalls, one long hold-off once traffic has built up
   int rsp_gap, hold_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap = 0;
         hold_left = 0;
      end else if (!big_stall_done && rsp_words == 60) begin
         big_stall_done = 1'b1;
         hold_left = 600;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_gap = pick_gap(rsp_burst);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_words++;
         if (expected_verdicts.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("ERROR: unexpected response word keep=%0b status=%0d",
                        rsp_ch.keep, rsp_ch.status);
         end else begin
            verdict_type e;
            e = expected_verdicts.pop_front();
            if (rsp_ch.keep !== e.keep || rsp_ch.status !== e.status) begin
               err_count++;
               if (err_count <= 10)
                  $display("ERROR: word %0d expected keep=%0b status=%0d, got keep=%0b status=%0d",
                           rsp_words, e.keep, e.status, rsp_ch.keep, rsp_ch.status);
            end
         end
      end
   end

   // stimulus helpers
   task automatic push_word(input logic kind, input logic [VBITS-1:0] value,
                            input logic first, input logic last);
      pending_words.push_back({kind, value, first, last});
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_ch.valid || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sigma(input logic [15:0] value);
      csr_ch.sigma_limit <= value;
      csr_ch.valid       <= 1'b1;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      mdl_sigma = value;
      sigma_writes++;
   endtask

   function automatic logic [VBITS-1:0] near_value(input logic [VBITS-1:0] base,
                                                   input int span);
      int v;
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, VMAX);
      v = int'(base) + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > int'(VMAX)) v = VMAX;
      return v;
   endfunction

   // one load pass followed by a classify pass
   task automatic random_set(output int words);
      int n, m, span;
      logic [VBITS-1:0] base;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      m = $urandom_range(1, 12);
      base = $urandom_range(0, VMAX);
      span = 1 << $urandom_range(4, 18);
      for (int i = 0; i < n; i++)
         push_word(esc_pkg::KIND_LOAD, near_value(base, span), i == 0, i == n - 1);
      for (int i = 0; i < m; i++)
         push_word(esc_pkg::KIND_CLASSIFY, near_value(base, 4 * span),
                   i == 0 && $urandom_range(0, 1), $urandom_range(0, 3) == 0);
      words = n + m;
   endtask

   // stray words with random fields
   task automatic noise_words(output int words);
      words = $urandom_range(1, 4);
      for (int i = 0; i < words; i++)
         push_word($urandom_range(0, 1), $urandom_range(0, VMAX),
                   $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = esc_pkg::KIND_LOAD;
      req_ch.error_value = '0;
      req_ch.first_of_set = 1'b0;
      req_ch.last_of_set = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.sigma_limit = esc_pkg::SIGMA_RESET;
      mdl_count = 0;
      mdl_median = '0;
      mdl_spread_sq = '0;
      mdl_overflow = 1'b0;
      mdl_first_pending = 1'b1;
      mdl_sigma = esc_pkg::SIGMA_RESET;
      err_count = 0;
      load_words = 0;
      cls_words = 0;
      rsp_words = 0;
      set_count = 0;
      sigma_writes = 0;
      big_stall_done = 1'b0;
      req_burst = 0;
      rsp_burst = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // classify with nothing loaded: only the first point is kept
      push_word(esc_pkg::KIND_CLASSIFY, 20'd5, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, '0, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, VMAX, 1'b0, 1'b1);
      // single-value load gives the few-values status
      push_word(esc_pkg::KIND_LOAD, VMAX, 1'b1, 1'b1);
      push_word(esc_pkg::KIND_CLASSIFY, VMAX, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, '0, 1'b0, 1'b0);
      // set with extremes, the last word appended without a start mark
      push_word(esc_pkg::KIND_LOAD, '0, 1'b1, 1'b0);
      push_word(esc_pkg::KIND_LOAD, VMAX, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_LOAD, 20'h10000, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_LOAD, 20'h12000, 1'b0, 1'b1);
      push_word(esc_pkg::KIND_LOAD, 20'h11000, 1'b0, 1'b1);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h11000, 1'b1, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, '0, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, VMAX, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h11800, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h11000, 1'b1, 1'b0);
      wait_idle();

      // threshold extremes against the same statistics
      write_sigma(16'd0);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h11000, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h11000, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, VMAX, 1'b0, 1'b0);
      wait_idle();
      write_sigma(16'hFFFF);
      push_word(esc_pkg::KIND_CLASSIFY, VMAX, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, '0, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_LOAD, 20'h00001, 1'b1, 1'b0);
      push_word(esc_pkg::KIND_LOAD, 20'h00001, 1'b0, 1'b1);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h00001, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, 20'h00001, 1'b0, 1'b0);
      push_word(esc_pkg::KIND_CLASSIFY, VMAX, 1'b0, 1'b0);
      wait_idle();

      // random phases, each under its own threshold
      for (int ph = 0; ph < 7; ph++) begin
         int sent, k, r;
         r = $urandom_range(0, 9);
         if (r == 0) write_sigma(16'd0);
         else if (r == 1) write_sigma(16'hFFFF);
         else if (r < 4) write_sigma($urandom_range(0, 16'hFFFF));
         else write_sigma($urandom_range(64, 1024));
         sent = 0;
         while (sent < 90) begin
            if ($urandom_range(0, 99) < 85) random_set(k);
            else noise_words(k);
            sent += k;
         end
         wait_idle();
      end

      $display("Covered %0d load and %0d classify words over %0d statistics passes,",
               load_words, cls_words, set_count);
      $display("%0d response words checked, %0d threshold writes.", rsp_words, sigma_writes);
      if (err_count == 0 && expected_verdicts.size() == 0) begin
         $display("error_sigma_clip_filter test passed");
      end else begin
         $display("%0d mismatches", err_count);
         $display("error_sigma_clip_filter test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #80ms;
      $display("ERROR: timeout");
      $display("error_sigma_clip_filter test failed");
      $finish;
   end

endmodule

/* error_sigma_clip_filter.f */
hdl/esc_pkg.sv
hdl/esc_if.sv
hdl/esc_ctrl.sv
hdl/esc_dp.sv
hdl/error_sigma_clip_filter.sv
hdl/esc_checker.sv
sim/tb_top.sv
